// File: hdl/adpb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adpb_pkg: shared types and constants of the DMA packet builder
// Register codes, header and segment flag bytes, job and word records.
// ----------------------------------------------------------------------------
package adpb_pkg;

    localparam logic [7:0] MAX_SEGMENTS = 8'd128;

    localparam logic [7:0] HDR_FLAGS    = 8'h0D;
    localparam logic [7:0] HDR_LEN_SHORT = 8'd2;
    localparam logic [7:0] HDR_LEN_LONG  = 8'd3;
    localparam logic [3:0] WORDS_SHORT  = 4'd8;
    localparam logic [3:0] WORDS_LONG   = 4'd10;

    localparam logic [7:0] SEG_ORDER    = 8'h10;
    localparam logic [7:0] SEG_TODEV    = 8'h20;
    localparam logic [7:0] SEG_LAST     = 8'h80;

    localparam logic [7:0] REG_NONE     = 8'h00;
    localparam logic [7:0] REG_CONTROL  = 8'h0E;
    localparam logic [7:0] REG_COUNT    = 8'h12;
    localparam logic [7:0] REG_LBA_LOW  = 8'h13;
    localparam logic [7:0] REG_LBA_MID  = 8'h14;
    localparam logic [7:0] REG_LBA_HIGH = 8'h15;
    localparam logic [7:0] REG_DEVICE   = 8'h16;
    localparam logic [7:0] REG_CMD_END  = 8'h97;

    localparam logic [7:0] VAL_ZERO     = 8'h00;
    localparam logic [7:0] VAL_IGNORE   = 8'h20;

    typedef enum logic [1:0] {
        JOB_CMD,
        JOB_SEG,
        JOB_ERR
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic        lba48;
        logic [7:0]  device_byte;
        logic [7:0]  command_code;
        logic [15:0] sector_count;
        logic [47:0] block_address;
        logic [31:0] seg_address;
        logic [28:0] seg_len8;
        logic        seg_last;
        logic [10:0] seg_start;
        logic        write_dir;
        logic [3:0]  mode_nibble;
    } t_job;

    typedef struct packed {
        logic [9:0]  word_index;
        logic [31:0] word_value;
        logic        run_last;
        logic        packet_end;
        logic        seg_error;
    } t_word;

    function automatic logic [31:0] pair_word(input logic [7:0] v0, input logic [7:0] r0,
                                              input logic [7:0] v1, input logic [7:0] r1);
        pair_word = {r1, v1, r0, v0};
    endfunction

endpackage
`default_nettype wire

// File: hdl/adpb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adpb_front: item intake and classification
// Tracks the open packet, turns each beat into a job and queues it.
// ----------------------------------------------------------------------------
module adpb_front import adpb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_req_type,
    input  wire logic        i_lba48,
    input  wire logic        i_is_write,
    input  wire logic [3:0]  i_xfer_mode,
    input  wire logic [7:0]  i_device_byte,
    input  wire logic [7:0]  i_command_code,
    input  wire logic [15:0] i_sector_count,
    input  wire logic [47:0] i_block_address,
    input  wire logic [31:0] i_seg_address,
    input  wire logic [31:0] i_seg_length,
    input  wire logic        i_seg_last,
    output logic             o_job_valid,
    output t_job             o_job,
    input  wire logic        i_job_pop
);

    logic       r_packet_open, n_packet_open;
    logic       r_long_header, n_long_header;
    logic       r_write_dir, n_write_dir;
    logic [3:0] r_mode_nibble, n_mode_nibble;
    logic [7:0] r_segment_count, n_segment_count;

    t_job       n_job;
    t_job       r_jobq [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       accept;
    logic       job_pop;

    assign full        = (r_count == 2'd2);
    assign accept      = push && !full;
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_jobq[r_rd_ptr];
    assign job_pop     = i_job_pop && o_job_valid;

    always_comb begin
        n_packet_open   = r_packet_open;
        n_long_header   = r_long_header;
        n_write_dir     = r_write_dir;
        n_mode_nibble   = r_mode_nibble;
        n_segment_count = r_segment_count;

        n_job.lba48         = i_lba48;
        n_job.device_byte   = i_device_byte;
        n_job.command_code  = i_command_code;
        n_job.sector_count  = i_sector_count;
        n_job.block_address = i_block_address;
        n_job.seg_address   = i_seg_address;
        n_job.seg_len8      = i_seg_length[31:3];
        n_job.seg_last      = i_seg_last;
        n_job.seg_start     = (r_long_header ? 11'd10 : 11'd8)
                            + {1'b0, r_segment_count, 2'b00};
        n_job.write_dir     = r_write_dir;
        n_job.mode_nibble   = r_mode_nibble;

        if (!i_req_type) begin
            n_job.kind      = JOB_CMD;
            n_packet_open   = 1'b1;
            n_long_header   = i_lba48;
            n_write_dir     = i_is_write;
            n_mode_nibble   = i_xfer_mode;
            n_segment_count = 8'd0;
        end else if (!r_packet_open || (r_segment_count >= MAX_SEGMENTS)) begin
            n_job.kind = JOB_ERR;
        end else begin
            n_job.kind      = JOB_SEG;
            n_segment_count = r_segment_count + 8'd1;
            if (i_seg_last) begin
                n_packet_open = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_open   <= 1'b0;
            r_long_header   <= 1'b0;
            r_write_dir     <= 1'b0;
            r_mode_nibble   <= 4'd0;
            r_segment_count <= 8'd0;
        end else if (accept) begin
            r_packet_open   <= n_packet_open;
            r_long_header   <= n_long_header;
            r_write_dir     <= n_write_dir;
            r_mode_nibble   <= n_mode_nibble;
            r_segment_count <= n_segment_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (accept) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (job_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, accept} - {1'b0, job_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_jobq[r_wr_ptr] <= n_job;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("job queue count out of range");

    a_cmd_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_req_type) |=> (r_packet_open && (r_segment_count == 8'd0)))
        else $error("command did not open a fresh packet");

    a_seg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_segment_count <= MAX_SEGMENTS) else $error("segment count past limit");

endmodule
`default_nettype wire

// File: hdl/adpb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adpb_back: packet word emitter
// Walks each queued job one word per cycle into a two-entry result queue, stalling while it is full.
// ----------------------------------------------------------------------------
module adpb_back import adpb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_packet_base,
    input  wire logic        i_job_valid,
    input  wire t_job        i_job,
    output logic             o_job_pop,
    output logic             empty,
    input  wire logic        pop,
    output t_word            o_word
);

    logic [3:0]  r_beat;
    logic        last_word;
    logic        emit;
    logic        outq_full;
    logic        out_pop;
    logic [3:0]  cmd_words;
    logic [7:0]  hdr_len;
    logic [10:0] next_idx;
    logic [31:0] addend;
    logic [31:0] chain_ptr;
    logic [7:0]  seg_flags;
    t_word       n_word;
    t_word       r_outq [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;

    assign cmd_words = i_job.lba48 ? WORDS_LONG : WORDS_SHORT;
    assign hdr_len   = i_job.lba48 ? HDR_LEN_LONG : HDR_LEN_SHORT;
    assign next_idx  = i_job.seg_start + 11'd4;
    assign addend    = (i_job.kind == JOB_CMD) ? {26'd0, cmd_words, 2'b00}
                                               : {19'd0, next_idx, 2'b00};
    assign chain_ptr = i_packet_base + addend;
    assign seg_flags = SEG_ORDER | (i_job.write_dir ? SEG_TODEV : 8'h00)
                     | (i_job.seg_last ? SEG_LAST : 8'h00);

    assign outq_full = (r_count == 2'd2);
    assign emit      = i_job_valid && !outq_full;
    assign o_job_pop = emit && last_word;
    assign empty     = (r_count == 2'd0);
    assign out_pop   = pop && !empty;
    assign o_word    = r_outq[r_rd_ptr];

    always_comb begin
        case (i_job.kind)
            JOB_CMD: last_word = (r_beat == (cmd_words - 4'd1));
            JOB_SEG: last_word = (r_beat == 4'd3);
            default: last_word = 1'b1;
        endcase
    end

    always_comb begin
        n_word.run_last   = last_word;
        n_word.packet_end = 1'b0;
        n_word.seg_error  = 1'b0;
        n_word.word_index = 10'd0;
        n_word.word_value = 32'd0;
        case (i_job.kind)
            JOB_CMD: begin
                n_word.word_index = {6'd0, r_beat};
                case (r_beat)
                    4'd0: n_word.word_value = {hdr_len, HDR_FLAGS, 16'h0000};
                    4'd1: n_word.word_value = i_packet_base;
                    4'd2: n_word.word_value = chain_ptr;
                    4'd3: n_word.word_value = 32'd0;
                    4'd4: n_word.word_value = i_job.lba48
                        ? pair_word(i_job.device_byte, REG_DEVICE,
                                    i_job.sector_count[15:8], REG_COUNT)
                        : pair_word(i_job.device_byte, REG_DEVICE,
                                    i_job.sector_count[7:0], REG_COUNT);
                    4'd5: n_word.word_value = i_job.lba48
                        ? pair_word(i_job.block_address[31:24], REG_LBA_LOW,
                                    i_job.block_address[39:32], REG_LBA_MID)
                        : pair_word(i_job.block_address[7:0], REG_LBA_LOW,
                                    i_job.block_address[15:8], REG_LBA_MID);
                    4'd6: n_word.word_value = i_job.lba48
                        ? pair_word(i_job.block_address[47:40], REG_LBA_HIGH,
                                    i_job.sector_count[7:0], REG_COUNT)
                        : pair_word(i_job.block_address[23:16], REG_LBA_HIGH,
                                    VAL_ZERO, REG_CONTROL);
                    4'd7: n_word.word_value = i_job.lba48
                        ? pair_word(i_job.block_address[7:0], REG_LBA_LOW,
                                    i_job.block_address[15:8], REG_LBA_MID)
                        : pair_word(VAL_IGNORE, REG_NONE,
                                    i_job.command_code, REG_CMD_END);
                    4'd8: n_word.word_value = pair_word(i_job.block_address[23:16],
                                    REG_LBA_HIGH, VAL_ZERO, REG_CONTROL);
                    4'd9: n_word.word_value = pair_word(VAL_IGNORE, REG_NONE,
                                    i_job.command_code, REG_CMD_END);
                    default: n_word.word_value = 32'd0;
                endcase
            end
            JOB_SEG: begin
                n_word.word_index = i_job.seg_start[9:0] + {8'd0, r_beat[1:0]};
                n_word.packet_end = last_word && i_job.seg_last;
                case (r_beat[1:0])
                    2'd0:    n_word.word_value = i_job.seg_address;
                    2'd1:    n_word.word_value = {3'd0, i_job.seg_len8};
                    2'd2:    n_word.word_value = {20'd0, i_job.mode_nibble, seg_flags};
                    default: n_word.word_value = i_job.seg_last ? 32'd0 : chain_ptr;
                endcase
            end
            default: begin
                n_word.seg_error = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= 4'd0;
        end else if (emit) begin
            r_beat <= last_word ? 4'd0 : (r_beat + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (emit) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (out_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, emit} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_outq[r_wr_ptr] <= n_word;
        end
    end

    a_outq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("result queue count out of range");

    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beat != 4'd0) |-> i_job_valid) else $error("word walk without a job");

    a_beat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beat != 4'd0) |-> (r_beat < WORDS_LONG)) else $error("word walk overran");

endmodule
`default_nettype wire

// File: hdl/ata_dma_packet_builder.sv
// The first word of an item reaches the result ports through the registered job
// queue and then the registered result queue.
// Throughput: one packet word per cycle from a single word emitter while the
// result queue has room; a command is 8 (short) or 10 (48-bit) words, a segment 4
// words and a rejected segment 1. Reset: synchronous, active low; clears the open
// packet state, both queues and packet_base; no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// ata_dma_packet_builder: DMA command packet builder, top level
// Holds packet_base and joins the intake front to the word emitter.
// ----------------------------------------------------------------------------
module ata_dma_packet_builder import adpb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_req_type,
    input  wire logic        i_lba48,
    input  wire logic        i_is_write,
    input  wire logic [3:0]  i_xfer_mode,
    input  wire logic [7:0]  i_device_byte,
    input  wire logic [7:0]  i_command_code,
    input  wire logic [15:0] i_sector_count,
    input  wire logic [47:0] i_block_address,
    input  wire logic [31:0] i_seg_address,
    input  wire logic [31:0] i_seg_length,
    input  wire logic        i_seg_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [9:0]       o_word_index,
    output logic [31:0]      o_word_value,
    output logic             o_run_last,
    output logic             o_packet_end,
    output logic             o_seg_error
);

    logic [31:0] r_packet_base;
    logic        job_valid;
    logic        job_pop;
    t_job        job;
    t_word       word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_base <= 32'd0;
        end else if (i_cfg_wr_en) begin
            r_packet_base <= i_cfg_wr_data;
        end
    end

    adpb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_req_type      (i_req_type),
        .i_lba48         (i_lba48),
        .i_is_write      (i_is_write),
        .i_xfer_mode     (i_xfer_mode),
        .i_device_byte   (i_device_byte),
        .i_command_code  (i_command_code),
        .i_sector_count  (i_sector_count),
        .i_block_address (i_block_address),
        .i_seg_address   (i_seg_address),
        .i_seg_length    (i_seg_length),
        .i_seg_last      (i_seg_last),
        .o_job_valid     (job_valid),
        .o_job           (job),
        .i_job_pop       (job_pop)
    );

    adpb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_packet_base (r_packet_base),
        .i_job_valid   (job_valid),
        .i_job         (job),
        .o_job_pop     (job_pop),
        .empty         (empty),
        .pop           (pop),
        .o_word        (word)
    );

    assign o_word_index = word.word_index;
    assign o_word_value = word.word_value;
    assign o_run_last   = word.run_last;
    assign o_packet_end = word.packet_end;
    assign o_seg_error  = word.seg_error;

endmodule
`default_nettype wire
